@@ rtl/cfr_pkg.sv @@
// shared constants, types and the crc step for the cobs frame receiver
`timescale 1ns / 1ps
package cfr_pkg;

    localparam int FRAME_BYTES   = 160;
    localparam int PAYLOAD_BYTES = 152;

    localparam int FILL_W = $clog2(FRAME_BYTES + 1);
    localparam int FA_W   = $clog2(FRAME_BYTES);
    localparam int PM_AW  = $clog2(2 * PAYLOAD_BYTES);
    localparam int SUM_W  = ((FILL_W > 8) ? FILL_W : 8) + 1;
    localparam int HDR_BYTES = 6;
    localparam int OVH_BYTES = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  CODE_MAX = 8'hFF;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_ACCEPT = 3'd1;
    localparam logic [2:0] ST_DROP   = 3'd2;
    localparam logic [2:0] ST_OVF    = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;

    typedef struct packed {
        logic capture;
        logic disp;
        logic rd_res;
        logic start;
        logic eval;
        logic zero;
        logic fin;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic act_read;
        logic rx_zero;
        logic fill_zero;
        logic bad_code;
        logic group_end;
        logic more;
        logic out_free;
    } t_sts;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/cfr_ctrl.sv @@
// sequencer for the cobs frame receiver
`timescale 1ns / 1ps
module cfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cfr_pkg::t_sts i_sts,
    output cfr_pkg::t_cmd o_cmd
);
    import cfr_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DISP  = 9'b000000010,
        S_RDRES = 9'b000000100,
        S_START = 9'b000001000,
        S_FETCH = 9'b000010000,
        S_EVAL  = 9'b000100000,
        S_ZERO  = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_PUSH  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                o_cmd.disp = 1'b1;
                priority if (i_sts.act_read) n_state = S_RDRES;
                else if (!i_sts.rx_zero || i_sts.fill_zero) n_state = S_PUSH;
                else n_state = S_START;
            end
            S_RDRES: begin
                o_cmd.rd_res = 1'b1;
                n_state = S_PUSH;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                priority if (i_sts.bad_code) n_state = S_FIN;
                else if (i_sts.group_end) n_state = S_ZERO;
                else n_state = S_FETCH;
            end
            S_ZERO: begin
                o_cmd.zero = 1'b1;
                n_state = i_sts.more ? S_FETCH : S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ rtl/cfr_datapath.sv @@
// buffers, cobs decode walk, crc check, latched frame fields and output register
`timescale 1ns / 1ps
module cfr_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cfr_pkg::t_cmd i_cmd,
    output cfr_pkg::t_sts o_sts,
    input  logic          i_action,
    input  logic [7:0]    i_rx_byte,
    input  logic [7:0]    i_read_index,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [2:0]    o_status,
    output logic [7:0]    o_message_type,
    output logic [15:0]   o_sequence_res,
    output logic [7:0]    o_payload_length,
    output logic [7:0]    o_read_data
);
    import cfr_pkg::*;

    logic [7:0] r_fmem [FRAME_BYTES];
    logic [7:0] r_pmem [2 * PAYLOAD_BYTES];

    logic              r_act;
    logic [7:0]        r_rx, r_idx, r_ver_cfg;
    logic [FILL_W-1:0] r_fill, r_rd, r_wr;
    logic [7:0]        r_mq, r_pq, r_rem;
    logic              r_ff, r_bad, r_bank;
    logic [15:0]       r_crc;
    logic [7:0]        r_p0, r_p1;
    logic [1:0]        r_pcnt;
    logic [7:0]        r_dver, r_dtype;
    logic [15:0]       r_dseq, r_dplen;
    logic [7:0]        r_type, r_len;
    logic [15:0]       r_seq;
    logic [2:0]        r_res_st;
    logic [7:0]        r_res_data;
    logic              r_ov;

    logic              emit_en;
    logic [7:0]        emit_b;
    logic [SUM_W-1:0]  code_end;
    logic              bad_now;
    logic [PM_AW-1:0]  wbase, rbase, pw_addr, pr_addr;
    logic [FILL_W-1:0] poff;
    logic              pw_en;
    logic              frame_ok;

    assign code_end = SUM_W'(r_rd) + SUM_W'(r_mq);
    assign bad_now  = (r_rem == 8'd0) && (code_end > SUM_W'(r_fill));

    assign o_sts.act_read  = r_act;
    assign o_sts.rx_zero   = (r_rx == 8'd0);
    assign o_sts.fill_zero = (r_fill == '0);
    assign o_sts.bad_code  = bad_now;
    assign o_sts.group_end = (r_rem == 8'd0) ? (r_mq == 8'd1) : (r_rem == 8'd1);
    assign o_sts.more      = (r_rd < r_fill);
    assign o_sts.out_free  = !r_ov || i_out_ready;

    // decoded byte stream
    always_comb begin
        emit_en = 1'b0;
        emit_b  = 8'd0;
        if (i_cmd.eval && r_rem != 8'd0) begin
            emit_en = 1'b1;
            emit_b  = r_mq;
        end else if (i_cmd.zero && !r_ff && (r_rd < r_fill)) begin
            emit_en = 1'b1;
        end
    end

    assign wbase   = r_bank ? PM_AW'(0) : PM_AW'(PAYLOAD_BYTES);
    assign rbase   = r_bank ? PM_AW'(PAYLOAD_BYTES) : PM_AW'(0);
    assign poff    = r_wr - FILL_W'(HDR_BYTES);
    assign pw_en   = emit_en && (r_wr >= FILL_W'(HDR_BYTES))
                     && (poff < FILL_W'(PAYLOAD_BYTES));
    assign pw_addr = wbase + PM_AW'(poff);
    assign pr_addr = (r_idx < r_len) ? (rbase + PM_AW'(r_idx)) : rbase;

    assign frame_ok = !r_bad && (r_wr >= FILL_W'(OVH_BYTES))
                      && (17'(r_wr) == 17'(r_dplen) + 17'(OVH_BYTES))
                      && (r_dplen <= 16'(PAYLOAD_BYTES))
                      && (r_dver == r_ver_cfg)
                      && (r_crc == {r_p1, r_p0});

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.disp && !r_act && r_rx != 8'd0 && r_fill < FILL_W'(FRAME_BYTES)) begin
            r_fmem[r_fill[FA_W-1:0]] <= r_rx;
        end
        r_mq <= r_fmem[r_rd[FA_W-1:0]];
        if (pw_en) r_pmem[pw_addr] <= emit_b;
        r_pq <= r_pmem[pr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ver_cfg <= 8'd2;
            r_fill    <= '0;
            r_bank    <= 1'b0;
            r_type    <= 8'd0;
            r_seq     <= 16'd0;
            r_len     <= 8'd0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_valid) r_ver_cfg <= i_cfg_data;
            if (i_cmd.disp && !r_act && r_rx != 8'd0) begin
                if (r_fill < FILL_W'(FRAME_BYTES)) r_fill <= r_fill + 1'b1;
                else r_fill <= '0;
            end
            if (i_cmd.fin) begin
                r_fill <= '0;
                if (frame_ok) begin
                    r_type <= r_dtype;
                    r_seq  <= r_dseq;
                    r_len  <= r_dplen[7:0];
                    r_bank <= ~r_bank;
                end
            end
            if (i_cmd.push) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    // item capture, walk state and pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= i_action;
            r_rx  <= i_rx_byte;
            r_idx <= i_read_index;
        end
        if (i_cmd.disp) begin
            r_res_data <= 8'd0;
            if (!r_act && r_rx != 8'd0 && r_fill >= FILL_W'(FRAME_BYTES)) r_res_st <= ST_OVF;
            else r_res_st <= ST_OK;
        end
        if (i_cmd.rd_res) begin
            r_res_st   <= ST_READ;
            r_res_data <= (r_idx < r_len) ? r_pq : 8'd0;
        end
        if (i_cmd.start) begin
            r_rd   <= '0;
            r_wr   <= '0;
            r_rem  <= 8'd0;
            r_ff   <= 1'b0;
            r_bad  <= 1'b0;
            r_crc  <= CRC_INIT;
            r_pcnt <= 2'd0;
        end
        if (i_cmd.eval) begin
            if (r_rem == 8'd0) begin
                if (bad_now) begin
                    r_bad <= 1'b1;
                end else begin
                    r_rem <= r_mq - 8'd1;
                    r_ff  <= (r_mq == CODE_MAX);
                    r_rd  <= r_rd + 1'b1;
                end
            end else begin
                r_rem <= r_rem - 8'd1;
                r_rd  <= r_rd + 1'b1;
            end
        end
        if (emit_en) begin
            unique case (r_wr)
                FILL_W'(0): r_dver        <= emit_b;
                FILL_W'(1): r_dtype       <= emit_b;
                FILL_W'(2): r_dseq[7:0]   <= emit_b;
                FILL_W'(3): r_dseq[15:8]  <= emit_b;
                FILL_W'(4): r_dplen[7:0]  <= emit_b;
                FILL_W'(5): r_dplen[15:8] <= emit_b;
                default: ;
            endcase
            if (r_pcnt == 2'd2) r_crc <= crc_byte(r_crc, r_p0);
            else r_pcnt <= r_pcnt + 2'd1;
            r_p0 <= r_p1;
            r_p1 <= emit_b;
            r_wr <= r_wr + 1'b1;
        end
        if (i_cmd.fin) begin
            r_res_st   <= frame_ok ? ST_ACCEPT : ST_DROP;
            r_res_data <= 8'd0;
        end
        if (i_cmd.push) begin
            o_status         <= r_res_st;
            o_read_data      <= r_res_data;
            o_message_type   <= r_type;
            o_sequence_res   <= r_seq;
            o_payload_length <= r_len;
        end
    end

    assign o_out_valid = r_ov;

endmodule

@@ rtl/cobs_crc16_frame_receiver.sv @@
// top level of the cobs frame receiver with crc-16 check
// a line byte passes the dispatch and push states and a read also the result read state, set by the sequencer;
//   the input is taken again in the cycle after the result is loaded
// a delimiter ending a frame walks its stored bytes through the fetch and eval states, with
//   a zero step per cobs group, paced by the one read port of the frame buffer
// one item at a time; a new item is taken while the previous result waits
// synchronous active-low reset: buffer empty, latched fields zero, version 2
`timescale 1ns / 1ps
module cobs_crc16_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_message_type,
    output logic [15:0] o_sequence_res,
    output logic [7:0]  o_payload_length,
    output logic [7:0]  o_read_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import cfr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: dispatch, decode walk, result push
    cfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // buffers, decode, crc and output register
    cfr_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_action),
        .i_rx_byte        (i_rx_byte),
        .i_read_index     (i_read_index),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_message_type   (o_message_type),
        .o_sequence_res   (o_sequence_res),
        .o_payload_length (o_payload_length),
        .o_read_data      (o_read_data)
    );

endmodule

@@ tb/sv/tb_frame_checker.sv @@
// checker for the cobs frame receiver: watches the channels, predicts results and compares
`timescale 1ns / 1ps
module tb_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_read_index,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_message_type,
    input  logic [15:0] i_sequence_res,
    input  logic [7:0]  i_payload_length,
    input  logic [7:0]  i_read_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import cfr_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  mtype;
        logic [15:0] seqn;
        logic [7:0]  plen;
        logic [7:0]  rdata;
    } t_rx_result;

    t_rx_result  expected_results[$];
    logic [7:0]  line_buf[FRAME_BYTES];
    int          line_fill;
    logic [7:0]  payload_mem[PAYLOAD_BYTES];
    logic [7:0]  cur_type;
    logic [15:0] cur_seq;
    int          cur_len;
    logic [7:0]  want_version;

    assign o_pending = expected_results.size();

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        o_fail_count++;
    endtask

    // decode the held line bytes and check the frame; updates latched fields on accept
    function automatic logic [2:0] close_frame();
        logic [7:0]  dec[FRAME_BYTES];
        logic [15:0] crc;
        int rd, wr, code, plen;
        rd = 0;
        wr = 0;
        while (rd < line_fill) begin
            code = line_buf[rd];
            rd++;
            if (code == 0 || rd + code - 1 > line_fill) return ST_DROP;
            for (int k = 1; k < code; k++) begin
                if (wr < FRAME_BYTES && rd < FRAME_BYTES) begin
                    dec[wr] = line_buf[rd];
                    wr++;
                end
                rd++;
            end
            if (code != 255 && rd < line_fill && wr < FRAME_BYTES) begin
                dec[wr] = 8'h00;
                wr++;
            end
        end
        if (wr < 8) return ST_DROP;
        plen = {dec[5], dec[4]};
        if (wr != 8 + plen || plen > PAYLOAD_BYTES) return ST_DROP;
        if (dec[0] != want_version) return ST_DROP;
        crc = 16'hFFFF;
        for (int i = 0; i < wr - 2; i++) begin
            crc ^= {dec[i], 8'h00};
            for (int b = 0; b < 8; b++) crc = crc[15] ? ((crc << 1) ^ 16'h1021) : (crc << 1);
        end
        if (crc != {dec[wr-1], dec[wr-2]}) return ST_DROP;
        cur_type = dec[1];
        cur_seq  = {dec[3], dec[2]};
        cur_len  = plen;
        for (int i = 0; i < plen; i++) payload_mem[i] = dec[6 + i];
        return ST_ACCEPT;
    endfunction

    always @(posedge i_clk) begin
        t_rx_result r, e;
        if (!i_rst_n) begin
            expected_results.delete();
            line_fill    = 0;
            cur_type     = 8'd0;
            cur_seq      = 16'd0;
            cur_len      = 0;
            want_version = 8'd2;
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) want_version = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                r = '{i_status, i_message_type, i_sequence_res, i_payload_length, i_read_data};
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    e = expected_results.pop_front();
                    if (r.status != e.status)
                        report_mismatch($sformatf("status %0d want %0d", r.status, e.status));
                    if (r.mtype != e.mtype)
                        report_mismatch($sformatf("type %0h want %0h", r.mtype, e.mtype));
                    if (r.seqn != e.seqn)
                        report_mismatch($sformatf("seq %0h want %0h", r.seqn, e.seqn));
                    if (r.plen != e.plen)
                        report_mismatch($sformatf("len %0d want %0d", r.plen, e.plen));
                    if (r.rdata != e.rdata)
                        report_mismatch($sformatf("data %0h want %0h", r.rdata, e.rdata));
                end
            end
            if (i_in_valid && i_in_ready) begin
                e.status = ST_OK;
                e.rdata  = 8'd0;
                if (i_action) begin
                    e.status = ST_READ;
                    if (i_read_index < cur_len) e.rdata = payload_mem[i_read_index];
                end else if (i_rx_byte != 8'd0) begin
                    if (line_fill < FRAME_BYTES) begin
                        line_buf[line_fill] = i_rx_byte;
                        line_fill++;
                    end else begin
                        line_fill = 0;
                        e.status  = ST_OVF;
                    end
                end else if (line_fill != 0) begin
                    e.status  = close_frame();
                    line_fill = 0;
                end
                e.mtype = cur_type;
                e.seqn  = cur_seq;
                e.plen  = cur_len[7:0];
                expected_results.push_back(e);
            end
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// testbench top: stimulus, configuration phases and verdict for the cobs frame receiver
`timescale 1ns / 1ps
module tb;
    import cfr_pkg::*;

    localparam logic ACT_LINE = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // kinds of frame damage
    localparam int CORR_NONE  = 0;
    localparam int CORR_CRC   = 1;
    localparam int CORR_LEN   = 2;
    localparam int CORR_VER   = 3;
    localparam int CORR_TRUNC = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic [7:0]  read_index = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [7:0]  message_type;
    logic [15:0] sequence_res;
    logic [7:0]  payload_length;
    logic [7:0]  read_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          items_sent = 0;
    logic [7:0]  cur_version = 8'd2;

    always #1 clk = ~clk;

    cobs_crc16_frame_receiver uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_action(action), .i_rx_byte(rx_byte), .i_read_index(read_index),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_status(status), .o_message_type(message_type), .o_sequence_res(sequence_res),
        .o_payload_length(payload_length), .o_read_data(read_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    tb_frame_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_action(action), .i_rx_byte(rx_byte), .i_read_index(read_index),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_status(status), .i_message_type(message_type), .i_sequence_res(sequence_res),
        .i_payload_length(payload_length), .i_read_data(read_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver side: ready toggles at random by the current stall rate
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one item on the input channel, with an optional random gap in front;
    // valid stays up after the accept until the next item or a drain replaces it
    task automatic send_item(input logic act, input logic [7:0] b, input logic [7:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        rx_byte    <= b;
        read_index <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_line(input logic [7:0] b);
        send_item(ACT_LINE, b, 8'($urandom_range(255)));
    endtask

    // hold off until every result is in, plus the longest frame walk
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_version(input logic [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        cur_version = v;
    endtask

    // build a frame, cobs encode it and send it with its delimiter
    task automatic send_frame(input int plen, input int corrupt, input bit zero_heavy);
        logic [7:0]  raw[$];
        logic [7:0]  enc[$];
        logic [15:0] crc;
        int          code_pos;
        raw.push_back(corrupt == CORR_VER ? cur_version + 8'd1 : cur_version);
        raw.push_back(8'($urandom_range(255)));
        raw.push_back(8'($urandom_range(255)));
        raw.push_back(8'($urandom_range(255)));
        raw.push_back(corrupt == CORR_LEN ? plen[7:0] + 8'd1 : plen[7:0]);
        raw.push_back(plen[15:8]);
        for (int i = 0; i < plen; i++)
            raw.push_back((zero_heavy && $urandom_range(1) != 0) ? 8'h00
                                                                 : 8'($urandom_range(255)));
        crc = 16'hFFFF;
        foreach (raw[i]) begin
            crc ^= {raw[i], 8'h00};
            for (int b = 0; b < 8; b++) crc = crc[15] ? ((crc << 1) ^ 16'h1021) : (crc << 1);
        end
        if (corrupt == CORR_CRC) crc ^= 16'h0001 << $urandom_range(15);
        raw.push_back(crc[7:0]);
        raw.push_back(crc[15:8]);
        // cobs: each group code counts bytes up to the next zero, 255 caps a group
        enc.push_back(8'h01);
        code_pos = 0;
        foreach (raw[i]) begin
            if (raw[i] == 0) begin
                code_pos = enc.size();
                enc.push_back(8'h01);
            end else begin
                enc.push_back(raw[i]);
                enc[code_pos]++;
                if (enc[code_pos] == 8'hFF && i != raw.size() - 1) begin
                    code_pos = enc.size();
                    enc.push_back(8'h01);
                end
            end
        end
        if (corrupt == CORR_TRUNC) void'(enc.pop_back());
        foreach (enc[i]) send_line(enc[i]);
        send_line(8'h00);
    endtask

    task automatic send_read();
        send_item(ACT_READ, 8'($urandom_range(255)), $urandom_range(3) == 0 ?
                  8'($urandom_range(255)) : 8'($urandom_range(payload_length + 1)));
    endtask

    // one random phase of mostly well-formed frames mixed with noise and reads
    task automatic random_phase(input int n_items);
        int stop_at;
        int pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_frame($urandom_range(9) == 0 ? $urandom_range(152) : $urandom_range(12),
                           $urandom_range(3) == 0 ? $urandom_range(CORR_CRC, CORR_TRUNC)
                                                  : CORR_NONE,
                           1'($urandom_range(1)));
            else if (pick < 80)
                repeat ($urandom_range(1, 4)) send_read();
            else if (pick < 90)
                send_line(8'($urandom_range(255)));
            else if (pick < 95)
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
            else
                send_line(8'h00);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle delimiter, reads before any frame, good and broken frames
        send_line(8'h00);
        send_item(ACT_READ, 8'hFF, 8'd0);
        send_frame(0, CORR_NONE, 0);
        send_frame(4, CORR_NONE, 1);
        send_read();
        send_item(ACT_READ, 8'h00, 8'd255);
        send_frame(3, CORR_CRC, 0);
        send_frame(2, CORR_LEN, 0);
        send_frame(2, CORR_VER, 0);
        send_frame(5, CORR_TRUNC, 0);
        send_line(8'h05);
        send_line(8'h00);
        // buffer full: 161st nonzero byte is an overflow discard
        repeat (161) send_line(8'hFF);
        send_line(8'h00);
        // largest payload whose encoding still fits the line buffer
        send_frame(151, CORR_NONE, 0);
        send_item(ACT_READ, 8'h00, 8'd150);
        send_item(ACT_READ, 8'h00, 8'd151);
        send_frame(151, CORR_NONE, 1);

        // pause until every result is in before going on
        drain();
        random_phase(240);

        send_idle_pct = 53;
        write_version(8'd0);
        random_phase(260);

        send_idle_pct = 0;
        recv_stall_pct = 53;
        write_version(8'd255);
        random_phase(260);

        send_idle_pct = 20;
        recv_stall_pct = 20;
        write_version(8'($urandom_range(255)));
        random_phase(260);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_version(8'd2);
        random_phase(240);

        drain();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/cfr_pkg.sv
rtl/cfr_ctrl.sv
rtl/cfr_datapath.sv
rtl/cobs_crc16_frame_receiver.sv
tb/sv/tb_frame_checker.sv
tb/sv/tb.sv
